// ----- hw/rtl/rcpw_pkg.sv -----
`timescale 1ns / 1ps

package rcpw_pkg;

  localparam int CHANNELS   = 3;
  localparam int ChanW      = 2;
  localparam int StampW     = 16;
  localparam int WidthW     = 16;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 16;
  localparam int ChanIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [WidthW-1:0] MinWidthReset = WidthW'(1000);
  localparam logic [WidthW-1:0] MaxWidthReset = WidthW'(2000);
  localparam logic              HalveReset    = 1'b1;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MIN_WIDTH   = 2'd0,
    CFG_MAX_WIDTH   = 2'd1,
    CFG_HALVE_WIDTH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [ChanW-1:0]  channel;
    logic              pin_level;
    logic [StampW-1:0] timestamp;
    logic              clear_after_read;
  } item_t;

  typedef struct packed {
    logic [WidthW-1:0] min_width;
    logic [WidthW-1:0] max_width;
    logic              halve_width;
  } cfg_t;

  // true when the channel number names an implemented channel
  function automatic logic chan_valid(input logic [ChanW-1:0] ch);
    logic [ChanW+ChanIdxW-1:0] wide;
    wide = {{ChanIdxW{1'b0}}, ch};
    return wide < (ChanW + ChanIdxW)'(CHANNELS);
  endfunction

  function automatic logic [ChanIdxW-1:0] chan_index(input logic [ChanW-1:0] ch);
    logic [ChanW+ChanIdxW-1:0] wide;
    wide = {{ChanIdxW{1'b0}}, ch};
    return wide[ChanIdxW-1:0];
  endfunction

endpackage

// ----- hw/rtl/rcpw_item_if.sv -----
`timescale 1ns / 1ps

interface rcpw_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [rcpw_pkg::ChanW-1:0]   channel;
  logic                         pin_level;
  logic [rcpw_pkg::StampW-1:0]  timestamp;
  logic                         clear_after_read;

  modport source (
    output valid, opcode, channel, pin_level, timestamp, clear_after_read,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, pin_level, timestamp, clear_after_read,
    output ready
  );
endinterface

// ----- hw/rtl/rcpw_result_if.sv -----
`timescale 1ns / 1ps

interface rcpw_result_if;
  logic                         valid;
  logic                         ready;
  logic [rcpw_pkg::WidthW-1:0]  width_value;

  modport source (output valid, width_value, input ready);
  modport sink (input valid, width_value, output ready);
endinterface

// ----- hw/rtl/rcpw_core.sv -----
`timescale 1ns / 1ps

module rcpw_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  rcpw_pkg::item_t             item,
  input  rcpw_pkg::cfg_t              cfg,
  output logic [rcpw_pkg::WidthW-1:0] width_value
);

  logic [rcpw_pkg::StampW-1:0] rise_stamp [rcpw_pkg::CHANNELS];
  logic [rcpw_pkg::WidthW-1:0] last_width [rcpw_pkg::CHANNELS];

  logic                          ch_ok;
  logic [rcpw_pkg::ChanIdxW-1:0] idx;
  logic [rcpw_pkg::StampW-1:0]   stamp;
  logic [rcpw_pkg::StampW-1:0]   rise_cur;
  logic [rcpw_pkg::WidthW-1:0]   width_cur;
  logic [rcpw_pkg::WidthW-1:0]   scaled;

  assign ch_ok     = rcpw_pkg::chan_valid(item.channel);
  assign idx       = rcpw_pkg::chan_index(item.channel);
  // zero stamp is reserved for "no rise seen"
  assign stamp     = (item.timestamp == '0) ? rcpw_pkg::StampW'(1) : item.timestamp;
  assign rise_cur  = rise_stamp[idx];
  assign width_cur = last_width[idx];
  assign scaled    = cfg.halve_width ? (width_cur >> 1) : width_cur;

  always_comb begin
    if (!ch_ok || scaled < cfg.min_width || scaled > cfg.max_width) begin
      width_value = '0;
    end else begin
      width_value = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rcpw_pkg::CHANNELS; i++) begin
        rise_stamp[i] <= '0;
        last_width[i] <= '0;
      end
    end else if (fire && ch_ok) begin
      case (item.opcode)
        rcpw_pkg::OP_EDGE: begin
          if (item.pin_level) begin
            rise_stamp[idx] <= stamp;
          end else if (rise_cur != '0) begin
            last_width[idx] <= stamp - rise_cur;
            rise_stamp[idx] <= '0;
          end
        end
        rcpw_pkg::OP_READ: begin
          if (item.clear_after_read) begin
            last_width[idx] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/rc_pulse_width_capture.sv -----
`timescale 1ns / 1ps

// rc pulse width capture, one item per clock unless a read beat is stalled
//
// item channel: edge beats (opcode edge) carry a channel, the new pin level
//   and a timer stamp; read beats (opcode read) ask for a channel's last
//   measured width and may clear it afterwards
// result channel: one beat per read beat, none per edge beat
// config port: cfg_wr_en/cfg_index/cfg_data write min_width, max_width and
//   halve_width; write only while no beat is in flight
//
// path: a read beat passes the input register, then the result register fed
//   by the channel file lookup
// throughput: one beat per cycle unless stalled; per-channel state is read and
//   written together, so back-to-back beats on one channel see each other
// reset: all stamps and widths clear, limits return to 1000..2000, halving on
// stall: a held result stops the input stage only once a read beat reaches
//   it; edges ahead of that read keep flowing, and the input register plus
//   result register absorb one read beat each
module rc_pulse_width_capture (
  input  logic                          clk,
  input  logic                          rst,
  rcpw_item_if.sink                     item,
  rcpw_result_if.source                 result,
  input  logic                          cfg_wr_en,
  input  logic [rcpw_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rcpw_pkg::CfgDataW-1:0]  cfg_data
);

  rcpw_pkg::cfg_t  cfg;
  rcpw_pkg::item_t hold;
  logic            hold_valid;
  logic            fire;
  logic            hold_is_read;
  logic            out_free;
  logic [rcpw_pkg::WidthW-1:0] core_width;
  logic            out_valid;
  logic [rcpw_pkg::WidthW-1:0] out_width;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_width   <= rcpw_pkg::MinWidthReset;
      cfg.max_width   <= rcpw_pkg::MaxWidthReset;
      cfg.halve_width <= rcpw_pkg::HalveReset;
    end else if (cfg_wr_en) begin
      case (rcpw_pkg::cfg_index_t'(cfg_index))
        rcpw_pkg::CFG_MIN_WIDTH:   cfg.min_width   <= cfg_data[rcpw_pkg::WidthW-1:0];
        rcpw_pkg::CFG_MAX_WIDTH:   cfg.max_width   <= cfg_data[rcpw_pkg::WidthW-1:0];
        rcpw_pkg::CFG_HALVE_WIDTH: cfg.halve_width <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input stage advances unless a read is blocked by an unaccepted result
  assign hold_is_read = (hold.opcode == rcpw_pkg::OP_READ);
  assign out_free     = !out_valid || result.ready;
  assign fire         = hold_valid && (!hold_is_read || out_free);
  assign item.ready   = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold.opcode           <= rcpw_pkg::opcode_t'(item.opcode);
      hold.channel          <= item.channel;
      hold.pin_level        <= item.pin_level;
      hold.timestamp        <= item.timestamp;
      hold.clear_after_read <= item.clear_after_read;
    end
  end

  // per-channel stamp and width file plus the read scaling and limit check
  rcpw_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (hold),
    .cfg         (cfg),
    .width_value (core_width)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && hold_is_read) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hold_is_read) begin
      out_width <= core_width;
    end
  end

  assign result.valid       = out_valid;
  assign result.width_value = out_width;

  // a processed read always lands in the result register
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_is_read) |=> out_valid)
    else $error("read beat produced no result");

  // an edge never creates a result
  a_edge_no_result: assert property (@(posedge clk) disable iff (rst)
    (fire && !hold_is_read && !out_valid) |=> !out_valid)
    else $error("edge beat produced a result");

  // a blocked input stage must hold off the item channel
  a_blocked_not_ready: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !fire) |-> !item.ready)
    else $error("input taken while stage blocked");

  // a read never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !(fire && hold_is_read))
    else $error("pending result overwritten");

endmodule
